// ----- rtl/sht_pkg.sv -----
// sht_pkg: shared types and codes for the sample history table.
// No dependencies.
package sht_pkg;

    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_LOOKUP = 3'd2;
    localparam logic [2:0] MODE_CLEAR  = 3'd3;
    localparam logic [2:0] MODE_MIN    = 3'd4;
    localparam logic [2:0] MODE_MAX    = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_UNDEF    = 3'd5;

    localparam logic [1:0] KIND_WRITER = 2'd0;
    localparam logic [1:0] KIND_READER = 2'd1;

    localparam logic CFG_KIND = 1'b0;
    localparam logic CFG_CAP  = 1'b1;

    typedef struct packed {
        logic [2:0]  mode;
        logic [62:0] seq_num;
        logic [63:0] writer_id_high;
        logic [63:0] writer_id_low;
        logic [15:0] payload_handle;
    } t_in_item;

    typedef struct packed {
        logic        success;
        logic [2:0]  status;
        logic [62:0] seq_out;
        logic [63:0] writer_out_high;
        logic [63:0] writer_out_low;
        logic [15:0] handle_out;
        logic [5:0]  position;
        logic        is_full;
        logic        is_empty;
    } t_out_item;

    // one stored entry
    typedef struct packed {
        logic [62:0] seq;
        logic [63:0] wh;
        logic [63:0] wl;
        logic [15:0] handle;
    } t_entry;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture input item, reset scan index
        logic rd;       // issue read at scan index
        logic step;     // evaluate read data, move index behind a match
        logic append;   // write new entry at count
        logic shift_wr; // write read data one below its read address
        logic clr;      // empty the table
        logic dec;      // drop count by one
        logic rd_best;  // read at best index
        logic emit;     // drive result
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_done;   // index reached count
        logic found;       // a match was seen
        logic empty;
        logic full;
    } t_stat;

endpackage

// ----- rtl/sht_ctrl.sv -----
// sht_ctrl: sequencer for the sample history table.
// Depends on sht_pkg.
module sht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [2:0]     i_mode,
    input  logic [1:0]     i_kind,
    input  sht_pkg::t_stat i_stat,
    output logic           o_busy,
    output sht_pkg::t_cmd  o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_BEST  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [2:0] r_mode;
    logic       r_rdv, n_rdv; // a read is in flight

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rdv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rdv   <= n_rdv;
        end
        if (i_start && r_state == S_IDLE) r_mode <= i_mode;
    end

    assign o_busy = (r_state != S_IDLE);

    // scan: one read per cycle, read data evaluated the cycle after
    always_comb begin
        n_state = r_state;
        n_rdv   = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                case (r_mode)
                    sht_pkg::MODE_ADD: begin
                        if (i_stat.full || i_kind == sht_pkg::KIND_WRITER
                            || i_kind != sht_pkg::KIND_READER)
                            n_state = S_DONE;
                        else
                            n_state = S_SCAN;
                    end
                    sht_pkg::MODE_REMOVE, sht_pkg::MODE_LOOKUP,
                    sht_pkg::MODE_MIN, sht_pkg::MODE_MAX: begin
                        n_state = S_SCAN;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (r_rdv) o_cmd.step = 1'b1;
                if (i_stat.found && (r_mode != sht_pkg::MODE_MIN)
                    && (r_mode != sht_pkg::MODE_MAX)) begin
                    n_state = (r_mode == sht_pkg::MODE_REMOVE) ? S_SHIFT : S_DONE;
                    o_cmd.step = 1'b0;
                end else if (i_stat.scan_done && !r_rdv) begin
                    n_state = (r_mode == sht_pkg::MODE_MIN || r_mode == sht_pkg::MODE_MAX)
                              ? S_BEST : S_DONE;
                end else if (!i_stat.scan_done) begin
                    o_cmd.rd = 1'b1;
                    n_rdv    = 1'b1;
                end
            end
            S_SHIFT: begin
                // read entry k+1, write it to k on the next cycle
                if (r_rdv) o_cmd.shift_wr = 1'b1;
                if (i_stat.scan_done && !r_rdv) begin
                    o_cmd.dec = 1'b1;
                    n_state   = S_EMIT;
                end else if (!i_stat.scan_done) begin
                    o_cmd.rd = 1'b1;
                    n_rdv    = 1'b1;
                end
            end
            S_BEST: begin
                if (!i_stat.empty) o_cmd.rd_best = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (r_mode == sht_pkg::MODE_ADD && !i_stat.full && !i_stat.found
                    && (i_kind == sht_pkg::KIND_WRITER || i_kind == sht_pkg::KIND_READER))
                    o_cmd.append = 1'b1;
                if (r_mode == sht_pkg::MODE_CLEAR) o_cmd.clr = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ----- rtl/sht_dp.sv -----
// sht_dp: entry memory, scan index, match and extreme search, result build.
// Depends on sht_pkg.
module sht_dp #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sht_pkg::t_in_item  i_item,
    input  logic [1:0]         i_kind,
    input  logic [6:0]         i_cap,
    input  sht_pkg::t_cmd      i_cmd,
    output sht_pkg::t_stat     o_stat,
    output logic               o_valid,
    output sht_pkg::t_out_item o_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sht_pkg::t_entry  r_mem [DEPTH];
    sht_pkg::t_entry  r_rdata;
    sht_pkg::t_in_item r_in;
    logic [CW-1:0] r_count;
    logic [62:0]   r_last;
    logic [CW-1:0] r_idx;      // next address to read
    logic [CW-1:0] r_ridx;     // address of data in r_rdata
    logic [CW-1:0] r_hit;      // matched index / best index / shift target
    logic [62:0]   r_best_seq;
    logic          r_found;
    sht_pkg::t_out_item r_out;
    logic [2:0]    r_mode;

    // effective capacity
    logic [CW-1:0] w_cap;
    logic          w_full;
    always_comb begin
        if (32'(i_cap) > DEPTH) w_cap = CW'(DEPTH);
        else                    w_cap = CW'(i_cap);
    end
    assign w_full = (r_count >= w_cap);

    // minimum or maximum search in progress
    logic w_mm;
    assign w_mm = (r_mode == sht_pkg::MODE_MIN || r_mode == sht_pkg::MODE_MAX);

    // match of the read entry
    logic w_seq_eq, w_match, w_better;
    assign w_seq_eq = (r_rdata.seq == r_in.seq_num);
    always_comb begin
        if (i_kind == sht_pkg::KIND_WRITER)
            w_match = w_seq_eq && (r_mode != sht_pkg::MODE_ADD);
        else if (i_kind == sht_pkg::KIND_READER)
            w_match = w_seq_eq && r_rdata.wh == r_in.writer_id_high
                      && r_rdata.wl == r_in.writer_id_low;
        else
            w_match = 1'b0;
        if (r_ridx == '0)
            w_better = 1'b1;
        else if (r_mode == sht_pkg::MODE_MIN)
            w_better = r_rdata.seq < r_best_seq;
        else
            w_better = r_rdata.seq >= r_best_seq;
    end

    assign o_stat.scan_done = (r_idx >= r_count);
    assign o_stat.found     = r_found;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = w_full;

    logic [62:0] w_next_seq;
    assign w_next_seq = r_last + 63'd1;

    // memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd)      r_rdata <= r_mem[r_idx[AW-1:0]];
        if (i_cmd.rd_best) r_rdata <= r_mem[r_hit[AW-1:0]];
        if (i_cmd.shift_wr) r_mem[r_hit[AW-1:0]] <= r_rdata;
        if (i_cmd.append) begin
            r_mem[r_count[AW-1:0]] <= '{
                seq:    (i_kind == sht_pkg::KIND_WRITER) ? w_next_seq : r_in.seq_num,
                wh:     r_in.writer_id_high,
                wl:     r_in.writer_id_low,
                handle: r_in.payload_handle};
        end
    end

    // control and scan registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_last  <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_in    <= i_item;
                r_mode  <= i_item.mode;
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            // a match restarts the index right behind it for the compaction
            if (i_cmd.step && !w_mm && w_match) begin
                r_idx <= r_ridx + CW'(1);
            end else if (i_cmd.rd) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.rd) r_ridx <= r_idx;
            if (i_cmd.step) begin
                if (w_mm) begin
                    if (w_better) begin
                        r_hit      <= r_ridx;
                        r_best_seq <= r_rdata.seq;
                    end
                end else if (w_match) begin
                    r_found <= 1'b1;
                    r_hit   <= r_ridx;
                    r_out.seq_out         <= r_rdata.seq;
                    r_out.writer_out_high <= r_rdata.wh;
                    r_out.writer_out_low  <= r_rdata.wl;
                    r_out.handle_out      <= r_rdata.handle;
                    r_out.position        <= 6'(r_ridx);
                end
            end
            if (i_cmd.shift_wr) r_hit <= r_hit + CW'(1);
            if (i_cmd.rd_best) r_out.position <= 6'(r_hit);
            if (i_cmd.append) begin
                if (i_kind == sht_pkg::KIND_WRITER) r_last <= w_next_seq;
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.dec) r_count <= r_count - CW'(1);
            if (i_cmd.clr) r_count <= '0;

            // add and clear outcome, set when the table is changed or found full
            if (i_cmd.load) begin
                r_out.success <= 1'b0;
                r_out.status  <= sht_pkg::ST_UNDEF;
            end
            if (i_cmd.append) begin
                r_out.status   <= sht_pkg::ST_OK;
                r_out.seq_out  <= (i_kind == sht_pkg::KIND_WRITER) ? w_next_seq
                                                                   : r_in.seq_num;
                r_out.position <= 6'(r_count);
            end else if (i_cmd.clr) begin
                r_out.success <= (r_count != '0);
                r_out.status  <= (r_count != '0) ? sht_pkg::ST_OK : sht_pkg::ST_EMPTY;
            end else if (r_mode == sht_pkg::MODE_ADD && i_cmd.emit == 1'b0 && !i_cmd.load
                         && !i_cmd.step && !i_cmd.rd && r_out.status == sht_pkg::ST_UNDEF
                         && w_full && !r_found) begin
                r_out.status <= sht_pkg::ST_FULL;
            end
        end
    end

    // result
    always_comb begin
        o_item = '0;
        o_valid = i_cmd.emit;
        o_item.is_full  = w_full;
        o_item.is_empty = (r_count == '0);
        case (r_mode)
            sht_pkg::MODE_ADD: begin
                if (r_found) begin
                    o_item.status = sht_pkg::ST_DUP;
                    o_item.seq_out = r_out.seq_out;
                    o_item.writer_out_high = r_out.writer_out_high;
                    o_item.writer_out_low = r_out.writer_out_low;
                    o_item.handle_out = r_out.handle_out;
                    o_item.position = r_out.position;
                end else if (r_out.status == sht_pkg::ST_OK) begin
                    o_item.success = 1'b1;
                    o_item.status = sht_pkg::ST_OK;
                    o_item.seq_out = r_out.seq_out;
                    o_item.writer_out_high = r_in.writer_id_high;
                    o_item.writer_out_low = r_in.writer_id_low;
                    o_item.handle_out = r_in.payload_handle;
                    o_item.position = r_out.position;
                end else begin
                    o_item.status = r_out.status;
                end
            end
            sht_pkg::MODE_REMOVE, sht_pkg::MODE_LOOKUP: begin
                if (r_found) begin
                    o_item.success = 1'b1;
                    o_item.status = sht_pkg::ST_OK;
                    o_item.seq_out = r_out.seq_out;
                    o_item.writer_out_high = r_out.writer_out_high;
                    o_item.writer_out_low = r_out.writer_out_low;
                    o_item.handle_out = r_out.handle_out;
                    o_item.position = r_out.position;
                end else begin
                    o_item.status = sht_pkg::ST_NOTFOUND;
                end
            end
            sht_pkg::MODE_CLEAR: begin
                o_item.success = r_out.success;
                o_item.status  = r_out.status;
            end
            sht_pkg::MODE_MIN, sht_pkg::MODE_MAX: begin
                if (r_count == '0) begin
                    o_item.status = sht_pkg::ST_EMPTY;
                end else begin
                    o_item.success = 1'b1;
                    o_item.status = sht_pkg::ST_OK;
                    o_item.seq_out = r_rdata.seq;
                    o_item.writer_out_high = r_rdata.wh;
                    o_item.writer_out_low = r_rdata.wl;
                    o_item.handle_out = r_rdata.handle;
                    o_item.position = r_out.position;
                end
            end
            default: o_item.status = sht_pkg::ST_UNDEF;
        endcase
        if (!w_mm) o_item.is_full = w_full;
    end
endmodule

// ----- rtl/sample_history_table.sv -----
// sample_history_table: top level, joins the sequencer and the datapath
// and holds the two configuration registers. Depends on sht_pkg, sht_ctrl, sht_dp.
//
// One operation is taken per start while busy is low; its single result
// appears on o_result for one cycle with o_done, and cannot be held off.
// Busy stays high until the operation ends, and the result comes in its last
// busy cycle. Add on the writer side, a refused add, clear and an undefined
// mode do not scan; lookup, remove, reader-side add, minimum and maximum scan
// the stored entries one memory read per cycle, and remove then moves each
// entry behind the removed one down a place per cycle. The entry memory has
// one read and one write port.
module sample_history_table #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  sht_pkg::t_in_item  i_item,
    output logic               o_done,
    output sht_pkg::t_out_item o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [6:0]         i_cfg_data
);
    logic [1:0] r_kind;
    logic [6:0] r_cap;
    sht_pkg::t_cmd  w_cmd;
    sht_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= sht_pkg::KIND_WRITER;
            r_cap  <= 7'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sht_pkg::CFG_KIND: r_kind <= i_cfg_data[1:0];
                sht_pkg::CFG_CAP:  r_cap  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sht_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_mode(i_item.mode),
        .i_kind(r_kind), .i_stat(w_stat), .o_busy(busy), .o_cmd(w_cmd)
    );

    sht_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .i_kind(r_kind),
        .i_cap(r_cap), .i_cmd(w_cmd), .o_stat(w_stat), .o_valid(o_done),
        .o_item(o_result)
    );

    // a result only comes while busy
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result outside an operation");
    // start while busy is ignored; a result ends the operation
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy) else $error("still busy after result");
    // success and ok status agree
    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.success == (o_result.status == sht_pkg::ST_OK)))
        else $error("success and status disagree");
endmodule
